>>> hdl/wsd_pkg.sv
// Shared types and constants for the WebSocket client receive deframer.
// Phase codes, result event codes and the result record used by all modules.
// No dependencies.
package wsd_pkg;

  // Parse phases
  localparam logic [2:0] PhIdle      = 3'd0;
  localparam logic [2:0] PhHandshake = 3'd1;
  localparam logic [2:0] PhHdr0      = 3'd2;
  localparam logic [2:0] PhHdr1      = 3'd3;
  localparam logic [2:0] PhExtLen    = 3'd4;
  localparam logic [2:0] PhMaskKey   = 3'd5;
  localparam logic [2:0] PhPayload   = 3'd6;

  // Result event codes
  localparam logic [3:0] EvText      = 4'd0;
  localparam logic [3:0] EvPong      = 4'd1;
  localparam logic [3:0] EvEmptyEnd  = 4'd2;
  localparam logic [3:0] EvEmptyPing = 4'd3;
  localparam logic [3:0] EvOpened    = 4'd4;
  localparam logic [3:0] EvRefused   = 4'd5;
  localparam logic [3:0] EvClose     = 4'd6;
  localparam logic [3:0] EvOversize  = 4'd7;
  localparam logic [3:0] EvAbandon   = 4'd8;

  // Frame opcodes
  localparam logic [3:0] OpCont  = 4'h0;
  localparam logic [3:0] OpText  = 4'h1;
  localparam logic [3:0] OpBin   = 4'h2;
  localparam logic [3:0] OpClose = 4'h8;
  localparam logic [3:0] OpPing  = 4'h9;

  // Handshake matching
  localparam int unsigned StatusLen    = 12;
  localparam logic [3:0]  StatusDone   = 4'd12;
  localparam logic [3:0]  StatusBad    = 4'd15;
  localparam logic [95:0] StatusText   = "HTTP/1.1 101";
  localparam logic [7:0]  ChCr         = 8'h0D;
  localparam logic [7:0]  ChLf         = 8'h0A;

  // Length field codes
  localparam logic [6:0] Len16Code = 7'd126;
  localparam logic [6:0] Len64Code = 7'd127;

  // Default maximum frame payload
  localparam logic [31:0] MaxPayloadReset = 32'd67108864;

  typedef struct packed {
    logic [3:0] event_res;
    logic [7:0] data_byte;
    logic       last;
  } wsd_result_t;

  // Expected status line byte at a match position (position below StatusLen)
  function automatic logic [7:0] status_char(input logic [3:0] idx);
    logic [3:0] pos;
    pos = 4'(StatusLen - 1) - idx;
    return StatusText[{pos, 3'b000} +: 8];
  endfunction

endpackage

>>> hdl/wsd_outbuf.sv
// Two-entry result buffer: output register plus skid slot.
// Lets the parser keep accepting while a result waits. Uses wsd_pkg.
module wsd_outbuf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  wsd_pkg::wsd_result_t push_data_i,
  output logic                space_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output wsd_pkg::wsd_result_t out_data_o
);
  import wsd_pkg::*;

  logic        out_valid_q, out_valid_d;
  logic        skid_valid_q, skid_valid_d;
  wsd_result_t out_q, out_d;
  wsd_result_t skid_q, skid_d;
  logic        pop;

  assign pop = out_valid_q & out_ready_i;

  // Next-state for head and skid slots
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else if (push_i) begin
        out_d = push_data_i;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (out_valid_q) begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end else begin
        out_d       = push_data_i;
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign space_o     = ~skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Skid slot only fills behind a held head entry
  a_skid_behind_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q) else $error("skid full with empty head");

  // No push arrives while both slots are taken
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_valid_q) else $error("push into full buffer");

  // A held head entry stays put until taken
  a_head_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_q)))
    else $error("head entry changed while held");

endmodule

>>> hdl/wsd_parser.sv
// Handshake matcher and frame parser: state registers and per-byte next-state logic.
// Produces at most one result per accepted byte. Uses wsd_pkg.
module wsd_parser #(
  parameter int unsigned LengthBits = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [31:0]          cfg_wdata_i,
  input  logic                 fire_i,
  input  logic                 kind_i,
  input  logic [7:0]           rx_byte_i,
  output logic                 res_valid_o,
  output wsd_pkg::wsd_result_t res_o
);
  import wsd_pkg::*;

  localparam int unsigned CmpW = (LengthBits > 32) ? LengthBits : 32;
  localparam int unsigned RemW = (LengthBits < 32) ? LengthBits : 32;

  logic [31:0]           max_len_q;
  logic [2:0]            phase_q, phase_d;
  logic [3:0]            stat_q, stat_d;
  logic [1:0]            term_q, term_d;
  logic                  fin_q, fin_d;
  logic [3:0]            op_q, op_d;
  logic                  masked_q, masked_d;
  logic [3:0]            lbl_q, lbl_d;
  logic [LengthBits-1:0] plen_q, plen_d;
  logic [RemW-1:0]       rem_q, rem_d;
  logic [31:0]           key_q, key_d;
  logic [1:0]            mpos_q, mpos_d;
  logic                  is_text_q, is_text_d;
  logic                  in_prog_q, in_prog_d;

  // Per-byte next state and result
  always_comb begin
    logic       len_done;
    logic       start_pl;
    logic       pl_end;
    logic       is_data_op;
    logic [7:0] key_byte;
    logic [7:0] dbyte;
    logic [7:0] exp_term;

    phase_d   = phase_q;
    stat_d    = stat_q;
    term_d    = term_q;
    fin_d     = fin_q;
    op_d      = op_q;
    masked_d  = masked_q;
    lbl_d     = lbl_q;
    plen_d    = plen_q;
    rem_d     = rem_q;
    key_d     = key_q;
    mpos_d    = mpos_q;
    is_text_d = is_text_q;
    in_prog_d = in_prog_q;
    res_valid_o = 1'b0;
    res_o       = '{event_res: EvText, data_byte: 8'h00, last: 1'b0};
    len_done  = 1'b0;
    start_pl  = 1'b0;
    pl_end    = 1'b0;
    is_data_op = (op_q == OpCont) || (op_q == OpText) || (op_q == OpBin);
    key_byte  = 8'(key_q >> {~mpos_q, 3'b000});
    dbyte     = masked_q ? (rx_byte_i ^ key_byte) : rx_byte_i;
    exp_term  = term_q[0] ? ChLf : ChCr;

    if (kind_i) begin
      // Connection start clears everything
      phase_d   = PhHandshake;
      stat_d    = '0;
      term_d    = '0;
      fin_d     = 1'b0;
      op_d      = '0;
      masked_d  = 1'b0;
      lbl_d     = '0;
      plen_d    = '0;
      rem_d     = '0;
      key_d     = '0;
      mpos_d    = '0;
      is_text_d = 1'b0;
      in_prog_d = 1'b0;
    end else begin
      case (phase_q)
        PhHandshake: begin
          if (stat_q < StatusDone) begin
            stat_d = (rx_byte_i == status_char(stat_q)) ? stat_q + 4'd1 : StatusBad;
          end
          if (rx_byte_i == exp_term) begin
            if (term_q == 2'd3) begin
              term_d      = 2'd0;
              res_valid_o = 1'b1;
              if (stat_d == StatusDone) begin
                phase_d         = PhHdr0;
                res_o.event_res = EvOpened;
              end else begin
                phase_d         = PhIdle;
                res_o.event_res = EvRefused;
              end
            end else begin
              term_d = term_q + 2'd1;
            end
          end else begin
            term_d = (rx_byte_i == ChCr) ? 2'd1 : 2'd0;
          end
        end
        PhHdr0: begin
          fin_d   = rx_byte_i[7];
          op_d    = rx_byte_i[3:0];
          phase_d = PhHdr1;
          // New data message while a text message is unfinished
          if ((op_d == OpText || op_d == OpBin) && in_prog_q && is_text_q) begin
            in_prog_d       = 1'b0;
            res_valid_o     = 1'b1;
            res_o.event_res = EvAbandon;
          end
        end
        PhHdr1: begin
          masked_d = rx_byte_i[7];
          if (rx_byte_i[6:0] == Len16Code || rx_byte_i[6:0] == Len64Code) begin
            lbl_d   = (rx_byte_i[6:0] == Len16Code) ? 4'd2 : 4'd8;
            plen_d  = '0;
            phase_d = PhExtLen;
          end else begin
            plen_d   = LengthBits'(rx_byte_i[6:0]);
            len_done = 1'b1;
          end
        end
        PhExtLen: begin
          if (plen_q[LengthBits-1 -: 8] != 8'h00) begin
            phase_d         = PhIdle;
            res_valid_o     = 1'b1;
            res_o.event_res = EvOversize;
          end else begin
            plen_d   = {plen_q[LengthBits-9:0], rx_byte_i};
            lbl_d    = lbl_q - 4'd1;
            len_done = (lbl_d == 4'd0);
          end
        end
        PhMaskKey: begin
          key_d = {key_q[23:0], rx_byte_i};
          if (mpos_q == 2'd3) begin
            start_pl = 1'b1;
          end else begin
            mpos_d = mpos_q + 2'd1;
          end
        end
        PhPayload: begin
          rem_d  = rem_q - RemW'(1);
          mpos_d = mpos_q + 2'd1;
          pl_end = (rem_d == '0);
          if (pl_end) begin
            phase_d = PhHdr0;
          end
          if (is_data_op) begin
            if (in_prog_q) begin
              if (pl_end && fin_q) begin
                in_prog_d = 1'b0;
              end
              if (is_text_q) begin
                res_valid_o = 1'b1;
                res_o       = '{event_res: EvText, data_byte: dbyte,
                                last: pl_end & fin_q};
              end
            end
          end else if (op_q == OpClose) begin
            if (pl_end) begin
              phase_d         = PhIdle;
              res_valid_o     = 1'b1;
              res_o.event_res = EvClose;
            end
          end else if (op_q == OpPing) begin
            res_valid_o = 1'b1;
            res_o       = '{event_res: EvPong, data_byte: dbyte, last: pl_end};
          end
        end
        default: begin
        end
      endcase

      // Length complete: size limit, then mask key or payload
      if (len_done) begin
        if (CmpW'(plen_d) > CmpW'(max_len_q)) begin
          phase_d         = PhIdle;
          res_valid_o     = 1'b1;
          res_o.event_res = EvOversize;
        end else if (masked_d) begin
          phase_d = PhMaskKey;
          mpos_d  = 2'd0;
          key_d   = '0;
        end else begin
          start_pl = 1'b1;
        end
      end

      // Payload start, with zero-length frames finished at once
      if (start_pl) begin
        rem_d   = RemW'(plen_q);
        mpos_d  = 2'd0;
        phase_d = PhPayload;
        if (len_done) begin
          rem_d = RemW'(plen_d);
        end
        if (op_q == OpText || op_q == OpBin) begin
          is_text_d = (op_q == OpText);
          in_prog_d = 1'b1;
        end
        if (rem_d == '0) begin
          phase_d = PhHdr0;
          if (is_data_op) begin
            if (in_prog_d && fin_q) begin
              in_prog_d = 1'b0;
              if (is_text_d) begin
                res_valid_o = 1'b1;
                res_o       = '{event_res: EvEmptyEnd, data_byte: 8'h00, last: 1'b1};
              end
            end
          end else if (op_q == OpClose) begin
            phase_d         = PhIdle;
            res_valid_o     = 1'b1;
            res_o.event_res = EvClose;
          end else if (op_q == OpPing) begin
            res_valid_o = 1'b1;
            res_o       = '{event_res: EvEmptyPing, data_byte: 8'h00, last: 1'b1};
          end
        end
      end
    end
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxPayloadReset;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  // Parse state, updated once per accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      stat_q    <= '0;
      term_q    <= '0;
      fin_q     <= 1'b0;
      op_q      <= '0;
      masked_q  <= 1'b0;
      lbl_q     <= '0;
      plen_q    <= '0;
      rem_q     <= '0;
      key_q     <= '0;
      mpos_q    <= '0;
      is_text_q <= 1'b0;
      in_prog_q <= 1'b0;
    end else if (fire_i) begin
      phase_q   <= phase_d;
      stat_q    <= stat_d;
      term_q    <= term_d;
      fin_q     <= fin_d;
      op_q      <= op_d;
      masked_q  <= masked_d;
      lbl_q     <= lbl_d;
      plen_q    <= plen_d;
      rem_q     <= rem_d;
      key_q     <= key_d;
      mpos_q    <= mpos_d;
      is_text_q <= is_text_d;
      in_prog_q <= in_prog_d;
    end
  end

  // Payload phase always owes at least one byte
  a_rem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhPayload |-> rem_q != '0) else $error("payload phase with nothing owed");

  // Only byte events carry data
  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && res_valid_o && res_o.event_res != EvText && res_o.event_res != EvPong)
    |-> res_o.data_byte == 8'h00) else $error("data on non-byte event");

  // Status index never leaves its legal codes
  a_stat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_q <= StatusDone || stat_q == StatusBad) else $error("bad status index");

endmodule

>>> hdl/websocket_client_deframer.sv
// Top level of the WebSocket client receive deframer.
// Instantiates wsd_parser and wsd_outbuf; uses wsd_pkg.
//
// One request is taken per clock while in_ready_o is high: each received byte (or
// connection start) is parsed combinationally and its result, if any, is written
// to a two-entry output buffer. in_ready_o drops only while both buffer entries
// are held by a stalled consumer, so with a free-running consumer the sustained
// rate is one byte per cycle and a result appears in the cycle after its byte is
// accepted. max_payload_len must be written through cfg_we_i/cfg_wdata_i while
// idle (the block does not enforce it); there is no clearing pass after reset.
module websocket_client_deframer #(
  parameter int unsigned LENGTH_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  event_res_o,
  output logic [7:0]  data_byte_o,
  output logic        last_o
);
  import wsd_pkg::*;

  logic        fire;
  logic        res_valid;
  logic        space;
  wsd_result_t res;
  wsd_result_t out_data;

  assign in_ready_o = space;
  assign fire       = in_valid_i & space;

  wsd_parser #(
    .LengthBits(LENGTH_BITS)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .fire_i     (fire),
    .kind_i     (kind_i),
    .rx_byte_i  (rx_byte_i),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  wsd_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (fire & res_valid),
    .push_data_i(res),
    .space_o    (space),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data)
  );

  assign event_res_o = out_data.event_res;
  assign data_byte_o = out_data.data_byte;
  assign last_o      = out_data.last;

endmodule

>>> verif/wsd_frame_checker.sv
// Scoreboard for the WebSocket client receive deframer: follows the request and
// result channels and the config port, predicts each result and compares it.
// Depends on wsd_pkg for the event, opcode and handshake constants.
module wsd_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        kind_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [3:0]  event_res_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import wsd_pkg::*;

  // Shadow copy of the deframer state
  logic [2:0]  ph;
  logic [3:0]  st_idx;
  logic [1:0]  term_idx;
  logic        fin;
  logic [3:0]  opc;
  logic        msk;
  logic [3:0]  len_left;
  logic [63:0] plen;
  logic [63:0] prem;
  logic [31:0] key;
  logic [1:0]  kpos;
  logic        msg_text;
  logic        msg_busy;
  logic [31:0] max_len;

  // Prediction of the current request
  bit          ev_hit;
  wsd_result_t ev_res;
  wsd_result_t want;
  wsd_result_t expected_events[$];
  int          fails = 0;
  int          pend = 0;

  assign fail_count_o = fails;
  assign pending_o    = pend;

  task automatic clear_parse();
    ph       = PhIdle;
    st_idx   = '0;
    term_idx = '0;
    fin      = 1'b0;
    opc      = '0;
    msk      = 1'b0;
    len_left = '0;
    plen     = '0;
    prem     = '0;
    key      = '0;
    kpos     = '0;
    msg_text = 1'b0;
    msg_busy = 1'b0;
  endtask

  task automatic emit(input logic [3:0] ev, input logic [7:0] d, input logic l);
    ev_hit           = 1'b1;
    ev_res.event_res = ev;
    ev_res.data_byte = d;
    ev_res.last      = l;
  endtask

  // Length known and mask key (if any) taken: enter the payload
  task automatic open_payload();
    prem = plen;
    kpos = '0;
    ph   = PhPayload;
    if (opc == OpText || opc == OpBin) begin
      msg_text = (opc == OpText);
      msg_busy = 1'b1;
    end
    if (prem == 0) begin
      ph = PhHdr0;
      if (opc == OpCont || opc == OpText || opc == OpBin) begin
        if (msg_busy && fin) begin
          msg_busy = 1'b0;
          if (msg_text) emit(EvEmptyEnd, 8'h00, 1'b1);
        end
      end else if (opc == OpClose) begin
        ph = PhIdle;
        emit(EvClose, 8'h00, 1'b0);
      end else if (opc == OpPing) begin
        emit(EvEmptyPing, 8'h00, 1'b1);
      end
    end
  endtask

  // Size limit, then mask key or payload
  task automatic check_length();
    if (plen > {32'd0, max_len}) begin
      ph = PhIdle;
      emit(EvOversize, 8'h00, 1'b0);
    end else if (msk) begin
      ph   = PhMaskKey;
      kpos = '0;
      key  = '0;
    end else begin
      open_payload();
    end
  endtask

  // One received request through the deframer
  task automatic deframe_byte(input logic k, input logic [7:0] b);
    logic [7:0] keyb;
    logic [7:0] d;
    logic       endp;
    logic       lastf;
    ev_hit = 1'b0;
    ev_res = '0;
    if (k) begin
      clear_parse();
      ph = PhHandshake;
      return;
    end
    case (ph)
      PhHandshake: begin
        if (st_idx < StatusDone) begin
          st_idx = (b == StatusText[8 * (StatusLen - 1 - st_idx) +: 8]) ? st_idx + 4'd1
                                                                        : StatusBad;
        end
        if (b == (term_idx[0] ? ChLf : ChCr)) begin
          if (term_idx == 2'd3) begin
            term_idx = '0;
            if (st_idx == StatusDone) begin
              ph = PhHdr0;
              emit(EvOpened, 8'h00, 1'b0);
            end else begin
              ph = PhIdle;
              emit(EvRefused, 8'h00, 1'b0);
            end
          end else begin
            term_idx = term_idx + 2'd1;
          end
        end else begin
          term_idx = (b == ChCr) ? 2'd1 : 2'd0;
        end
      end
      PhHdr0: begin
        fin = b[7];
        opc = b[3:0];
        ph  = PhHdr1;
        // a new data frame drops an unfinished text message
        if ((opc == OpText || opc == OpBin) && msg_busy && msg_text) begin
          msg_busy = 1'b0;
          emit(EvAbandon, 8'h00, 1'b0);
        end
      end
      PhHdr1: begin
        msk = b[7];
        if (b[6:0] == Len16Code || b[6:0] == Len64Code) begin
          len_left = (b[6:0] == Len16Code) ? 4'd2 : 4'd8;
          plen     = '0;
          ph       = PhExtLen;
        end else begin
          plen = {57'd0, b[6:0]};
          check_length();
        end
      end
      PhExtLen: begin
        if (plen[63:56] != 0) begin
          ph = PhIdle;
          emit(EvOversize, 8'h00, 1'b0);
        end else begin
          plen     = {plen[55:0], b};
          len_left = len_left - 4'd1;
          if (len_left == 0) check_length();
        end
      end
      PhMaskKey: begin
        key = {key[23:0], b};
        if (kpos == 2'd3) open_payload();
        else kpos = kpos + 2'd1;
      end
      PhPayload: begin
        keyb = key[8 * (3 - int'(kpos)) +: 8];
        d    = msk ? (b ^ keyb) : b;
        prem = prem - 64'd1;
        kpos = kpos + 2'd1;
        endp = (prem == 0);
        if (endp) ph = PhHdr0;
        if (opc == OpCont || opc == OpText || opc == OpBin) begin
          if (msg_busy) begin
            lastf = endp && fin;
            if (lastf) msg_busy = 1'b0;
            if (msg_text) emit(EvText, d, lastf);
          end
        end else if (opc == OpClose) begin
          if (endp) begin
            ph = PhIdle;
            emit(EvClose, 8'h00, 1'b0);
          end
        end else if (opc == OpPing) begin
          emit(EvPong, d, endp);
        end
      end
      default: ;
    endcase
  endtask

  // Compare results first, then predict the request taken at this edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parse();
      max_len = MaxPayloadReset;
      expected_events.delete();
      pend = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_events.size() == 0) begin
          if (fails < 10) begin
            $display("%0t: unexpected result ev=%0d data=%02h last=%0d",
                     $time, event_res_i, data_byte_i, last_i);
          end
          fails++;
        end else begin
          want = expected_events.pop_front();
          if (event_res_i !== want.event_res || data_byte_i !== want.data_byte ||
              last_i !== want.last) begin
            if (fails < 10) begin
              $display("%0t: mismatch, expected ev=%0d data=%02h last=%0d,",
                       $time, want.event_res, want.data_byte, want.last,
                       " got ev=%0d data=%02h last=%0d",
                       event_res_i, data_byte_i, last_i);
            end
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        deframe_byte(kind_i, rx_byte_i);
        if (ev_hit) expected_events.insert(expected_events.size(), ev_res);
      end
      if (cfg_we_i) max_len = cfg_wdata_i;
      pend = expected_events.size();
    end
  end

endmodule

>>> verif/tb.sv
// Testbench top for websocket_client_deframer: clock, reset, request stimulus
// (handshakes and frame streams), consumer stalls, watchdog and verdict.
// Depends on wsd_pkg and wsd_frame_checker for prediction and checking.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wsd_pkg::*;

  localparam logic [3:0] OpPong   = 4'hA;
  localparam int         IdleMax  = 2000;
  localparam int         NumItems = 1950;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        kind_i = 1'b0;
  logic [7:0]  rx_byte_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [3:0]  event_res_o;
  logic [7:0]  data_byte_o;
  logic        last_o;

  int          fail_count;
  int          pending;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          n_items = 0;
  int          idle_cycles = 0;
  logic [31:0] cur_max = MaxPayloadReset;

  websocket_client_deframer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .event_res_o (event_res_o),
    .data_byte_o (data_byte_o),
    .last_o      (last_o)
  );

  wsd_frame_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .kind_i       (kind_i),
    .rx_byte_i    (rx_byte_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .event_res_i  (event_res_o),
    .data_byte_i  (data_byte_o),
    .last_i       (last_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Consumer stalls
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: too long without any request or result moving
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleMax) begin
        $display("tb NOT OK");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Drive one request and hold it until taken; called and returns at a falling edge
  task automatic push_req(input logic k, input logic [7:0] b, input bit counts);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= k;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    if (counts) n_items++;
  endtask

  // Bytes the block drops while idle
  task automatic idle_noise();
    repeat ($urandom_range(3)) push_req(1'b0, 8'($urandom), 1'b0);
  endtask

  // Connection start and HTTP reply: 0 switching, 1 wrong status, 2 cut status line
  task automatic open_link(input int how);
    string status;
    int    n;
    int    roll;
    status = "HTTP/1.1 101";
    n = status.len();
    if (how == 1) status.putc($urandom_range(n - 1), 8'($urandom_range(126, 32)));
    if (how == 2) n = $urandom_range(n - 1);
    push_req(1'b1, 8'($urandom), 1'b1);
    for (int i = 0; i < n; i++) push_req(1'b0, status.getc(i), 1'b1);
    repeat ($urandom_range(6)) begin
      roll = $urandom_range(99);
      push_req(1'b0, (roll < 10) ? ChCr : (roll < 18) ? ChLf : 8'($urandom_range(126, 32)),
               1'b1);
    end
    repeat (2) begin
      push_req(1'b0, ChCr, 1'b1);
      push_req(1'b0, ChLf, 1'b1);
    end
  endtask

  // Mostly short payloads, clipped to the current size limit
  function automatic logic [63:0] pick_len();
    int          r;
    logic [63:0] l;
    r = $urandom_range(99);
    if (r < 70) l = 64'($urandom_range(8));
    else if (r < 96) l = 64'($urandom_range(40, 9));
    else l = 64'($urandom_range(300, 126));
    if (l > {32'd0, cur_max}) l = {32'd0, cur_max};
    return l;
  endfunction

  // One frame with random length coding and mask; payload only if within the limit.
  // With cut set, only a prefix of the frame is sent.
  task automatic send_frame(input logic fin, input logic [3:0] op, input logic [63:0] len,
                            input bit cut);
    logic [7:0] fq[$];
    int         roll;
    int         n;
    logic       msk;
    msk  = 1'($urandom);
    roll = $urandom_range(99);
    fq.insert(fq.size(), {fin, 3'($urandom), op});
    if (len < 126 && roll < 80) begin
      fq.insert(fq.size(), {msk, len[6:0]});
    end else if (len < 65536 && roll < 90) begin
      fq.insert(fq.size(), {msk, Len16Code});
      fq.insert(fq.size(), len[15:8]);
      fq.insert(fq.size(), len[7:0]);
    end else begin
      fq.insert(fq.size(), {msk, Len64Code});
      for (int i = 7; i >= 0; i--) fq.insert(fq.size(), len[8 * i +: 8]);
    end
    if (len <= {32'd0, cur_max}) begin
      if (msk) repeat (4) fq.insert(fq.size(), 8'($urandom));
      for (longint unsigned i = 0; i < len; i++) fq.insert(fq.size(), 8'($urandom));
    end
    n = fq.size();
    if (cut) n = $urandom_range(n - 1, 1);
    for (int i = 0; i < n; i++) push_req(1'b0, fq[i], 1'b1);
  endtask

  // A connection and a run of frames of mixed kinds
  task automatic run_session();
    int          how;
    int          nfr;
    int          roll;
    bit          ended;
    logic [3:0]  op;
    logic [63:0] len;
    roll = $urandom_range(99);
    how  = (roll < 85) ? 0 : (roll < 93) ? 1 : 2;
    open_link(how);
    if (how != 0) begin
      idle_noise();
      return;
    end
    nfr   = $urandom_range(12, 1);
    ended = 1'b0;
    for (int f = 0; f < nfr && !ended; f++) begin
      roll = $urandom_range(99);
      if (roll < 30) begin
        send_frame($urandom_range(99) < 55, OpText, pick_len(), 1'b0);
      end else if (roll < 50) begin
        send_frame(1'($urandom), OpCont, pick_len(), 1'b0);
      end else if (roll < 60) begin
        send_frame($urandom_range(99) < 60, OpBin, pick_len(), 1'b0);
      end else if (roll < 70) begin
        send_frame($urandom_range(99) < 80, OpPing, pick_len(), 1'b0);
      end else if (roll < 73) begin
        send_frame(1'($urandom), OpPong, pick_len(), 1'b0);
      end else if (roll < 80) begin
        // any opcode, reserved ones included
        op = 4'($urandom);
        send_frame(1'($urandom), op, pick_len(), 1'b0);
        if (op == OpClose) begin
          ended = 1'b1;
          idle_noise();
        end
      end else if (roll < 84) begin
        send_frame(1'($urandom), OpClose, pick_len(), 1'b0);
        ended = 1'b1;
        idle_noise();
      end else if (roll < 88) begin
        // length above the limit
        if (cur_max != '1 && $urandom_range(1) == 1) begin
          len = {32'd0, cur_max} + 64'($urandom_range(50)) + 64'd1;
        end else begin
          len = {32'($urandom) | 32'd1, 32'($urandom)};
        end
        send_frame(1'($urandom), 4'($urandom), len, 1'b0);
        ended = 1'b1;
        idle_noise();
      end else if (roll < 92) begin
        // frame broken off; the next connection start lands mid-frame
        send_frame(1'($urandom), 4'($urandom), pick_len(), 1'b1);
        ended = 1'b1;
      end else if (roll < 95) begin
        push_req(1'b0, 8'($urandom), 1'b1);
      end else begin
        send_frame(1'b1, OpText, pick_len(), 1'b0);
      end
    end
  endtask

  initial begin
    int          sess;
    int          cfg_step;
    logic [31:0] limit;
    sess     = 0;
    cfg_step = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: idle bytes, open, empty ping, masked text byte at the byte extremes
    push_req(1'b0, 8'hFF, 1'b0);
    push_req(1'b0, 8'h00, 1'b0);
    open_link(0);
    push_req(1'b0, {1'b1, 3'b000, OpPing}, 1'b1);
    push_req(1'b0, 8'h00, 1'b1);
    push_req(1'b0, {1'b1, 3'b111, OpText}, 1'b1);
    push_req(1'b0, 8'h81, 1'b1);
    repeat (4) push_req(1'b0, 8'hFF, 1'b1);
    push_req(1'b0, 8'h00, 1'b1);

    // Random sessions in three stall profiles, size limit changed every few sessions
    while (n_items < NumItems) begin
      if (n_items >= 2 * NumItems / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (n_items >= NumItems / 3) begin
        send_idle_pct = 55;
        recv_idle_pct = 38;
      end else begin
        send_idle_pct = 38;
        recv_idle_pct = 55;
      end
      if (sess % 4 == 0) begin
        case (cfg_step % 5)
          0:       limit = '1;
          1:       limit = '0;
          2:       limit = 32'($urandom_range(40, 1));
          3:       limit = $urandom;
          default: limit = 32'($urandom_range(400, 126));
        endcase
        cfg_step++;
        // let every result drain before touching the limit
        in_valid_i <= 1'b0;
        @(negedge clk_i);
        while (pending != 0) @(negedge clk_i);
        repeat (4) @(negedge clk_i);
        cfg_we_i    <= 1'b1;
        cfg_wdata_i <= limit;
        cur_max = limit;
        @(negedge clk_i);
        cfg_we_i <= 1'b0;
      end
      run_session();
      sess++;
    end

    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/wsd_pkg.sv
hdl/wsd_outbuf.sv
hdl/wsd_parser.sv
hdl/websocket_client_deframer.sv
verif/wsd_frame_checker.sv
verif/tb.sv
